[design/lcd_draw_command_sequencer_top_macros.svh]
// Assertion macros shared by the sequencer modules.
`ifndef LCD_DRAW_COMMAND_SEQUENCER_TOP_MACROS_SVH
`define LCD_DRAW_COMMAND_SEQUENCER_TOP_MACROS_SVH

// Clocked on clk_i and disabled while rst_ni is low.
`define LCDSEQ_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Same-cycle implication.
`define LCDSEQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  `LCDSEQ_ASSERT_RST(lbl, (ante) |-> (cons), msg)

`endif

[design/lcdseq_pkg.sv]
package lcdseq_pkg;

  localparam logic [2:0] ACT_PIXEL = 3'd0;
  localparam logic [2:0] ACT_FILL  = 3'd1;
  localparam logic [2:0] ACT_CHAR  = 3'd2;
  localparam logic [2:0] ACT_ROT   = 3'd3;
  localparam logic [2:0] ACT_NEXT  = 3'd4;
  localparam logic [2:0] ACT_LOAD  = 3'd5;

  localparam logic REG_GLYPH_W = 1'b0;
  localparam logic REG_GLYPH_H = 1'b1;

  localparam logic [7:0] CMD_CASET  = 8'h2A;
  localparam logic [7:0] CMD_RASET  = 8'h2B;
  localparam logic [7:0] CMD_RAMWR  = 8'h2C;
  localparam logic [7:0] CMD_MADCTL = 8'h36;

  localparam logic [7:0] CHAR_FIRST = 8'd32;
  localparam logic [7:0] CHAR_LAST  = 8'd126;

  localparam int unsigned FADDR_W = 14;

  localparam logic [3:0] WB_CASET = 4'd0;
  localparam logic [3:0] WB_XS_HI = 4'd1;
  localparam logic [3:0] WB_XS    = 4'd2;
  localparam logic [3:0] WB_XE_HI = 4'd3;
  localparam logic [3:0] WB_XE    = 4'd4;
  localparam logic [3:0] WB_RASET = 4'd5;
  localparam logic [3:0] WB_YS_HI = 4'd6;
  localparam logic [3:0] WB_YS    = 4'd7;
  localparam logic [3:0] WB_YE_HI = 4'd8;
  localparam logic [3:0] WB_YE    = 4'd9;
  localparam logic [3:0] WB_RAMWR = 4'd10;

  typedef enum logic [2:0] {
    SRC_WIN,
    SRC_PIX_HI,
    SRC_PIX_LO,
    SRC_ROT_CMD,
    SRC_ROT_DATA
  } src_e;

  typedef struct packed {
    logic       start_pixel;
    logic       start_fill;
    logic       start_char;
    logic       start_rot;
    logic       font_load;
    logic       emit;
    src_e       src;
    logic [3:0] win_idx;
    logic       pix_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pix_ok;
    logic char_ok;
    logic pix_last;
    logic out_free;
  } dp_stat_t;

  function automatic logic [7:0] madctl_of(input logic [1:0] rot);
    logic [7:0] m;
    unique case (rot)
      2'd0:    m = 8'hC0;
      2'd1:    m = 8'h80;
      2'd2:    m = 8'h00;
      default: m = 8'h40;
    endcase
    return m;
  endfunction

endpackage

[design/lcdseq_ctrl.sv]
module lcdseq_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [2:0]             action_i,
  input  lcdseq_pkg::dp_stat_t   stat_i,
  output logic                   in_stall_o,
  output lcdseq_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WIN,
    S_PIX,
    S_RD,
    S_CALC,
    S_ROTC,
    S_ROTD
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] win_idx_q, win_idx_d;
  logic       low_half_q, low_half_d;
  logic       ready, acc, is_next;

  always_comb begin
    ready = (state_q != S_RD) && (state_q != S_CALC) && stat_i.out_free;
  end

  assign in_stall_o = !ready;
  assign acc        = in_valid_i && ready;
  assign is_next    = acc && (action_i == lcdseq_pkg::ACT_NEXT);

  always_comb begin
    state_d    = state_q;
    win_idx_d  = win_idx_q;
    low_half_d = low_half_q;
    cmd_o      = '0;
    cmd_o.src  = lcdseq_pkg::SRC_WIN;
    cmd_o.win_idx = win_idx_q;
    cmd_o.font_load = acc && (action_i == lcdseq_pkg::ACT_LOAD);
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          unique case (action_i)
            lcdseq_pkg::ACT_PIXEL: begin
              if (stat_i.pix_ok) begin
                cmd_o.start_pixel = 1'b1;
                state_d = S_WIN;
              end
            end
            lcdseq_pkg::ACT_FILL: begin
              cmd_o.start_fill = 1'b1;
              state_d = S_WIN;
            end
            lcdseq_pkg::ACT_CHAR: begin
              if (stat_i.char_ok) begin
                cmd_o.start_char = 1'b1;
                state_d = S_WIN;
              end
            end
            lcdseq_pkg::ACT_ROT: begin
              cmd_o.start_rot = 1'b1;
              state_d = S_ROTC;
            end
            default: ;
          endcase
          win_idx_d  = lcdseq_pkg::WB_CASET;
          low_half_d = 1'b0;
        end
      end
      S_WIN: begin
        if (is_next) begin
          cmd_o.emit = 1'b1;
          if (win_idx_q == lcdseq_pkg::WB_RAMWR) begin
            state_d = S_PIX;
          end else begin
            win_idx_d = win_idx_q + 4'd1;
          end
        end
      end
      S_PIX: begin
        if (is_next) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_CALC;
      end
      S_CALC: begin
        cmd_o.emit     = 1'b1;
        cmd_o.src      = low_half_q ? lcdseq_pkg::SRC_PIX_LO : lcdseq_pkg::SRC_PIX_HI;
        cmd_o.pix_step = low_half_q;
        low_half_d     = !low_half_q;
        state_d        = (low_half_q && stat_i.pix_last) ? S_IDLE : S_PIX;
      end
      S_ROTC: begin
        if (is_next) begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = lcdseq_pkg::SRC_ROT_CMD;
          state_d    = S_ROTD;
        end
      end
      S_ROTD: begin
        if (is_next) begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = lcdseq_pkg::SRC_ROT_DATA;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      win_idx_q  <= lcdseq_pkg::WB_CASET;
      low_half_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      win_idx_q  <= win_idx_d;
      low_half_q <= low_half_d;
    end
  end

  `include "lcd_draw_command_sequencer_top_macros.svh"

  `LCDSEQ_ASSERT_RST(a_rd_then_calc, (state_q == S_RD) |=> (state_q == S_CALC), "read not followed by colour step")
  `LCDSEQ_ASSERT_IMPL(a_win_idx_range, state_q == S_WIN, win_idx_q <= lcdseq_pkg::WB_RAMWR, "window index out of range")

endmodule

[design/lcdseq_dp.sv]
module lcdseq_dp #(
  parameter int unsigned SCREEN_WIDTH  = 160,
  parameter int unsigned SCREEN_HEIGHT = 128,
  parameter int unsigned FONT_ROWS     = 4096
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lcdseq_pkg::ctrl_cmd_t  cmd_i,
  output lcdseq_pkg::dp_stat_t   stat_o,
  input  logic                   cfg_we_i,
  input  logic [0:0]             cfg_idx_i,
  input  logic [5:0]             cfg_wdata_i,
  input  logic [7:0]             pos_x_i,
  input  logic [7:0]             pos_y_i,
  input  logic [15:0]            fore_color_i,
  input  logic [15:0]            back_color_i,
  input  logic [7:0]             char_code_i,
  input  logic [1:0]             rotation_i,
  input  logic [11:0]            font_addr_i,
  input  logic [15:0]            font_row_i,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output logic                   is_data_o,
  output logic [7:0]             out_byte_o,
  output logic                   frame_end_o,
  output logic                   op_end_o
);

  localparam int unsigned AW = $clog2(FONT_ROWS);
  localparam int unsigned FW = lcdseq_pkg::FADDR_W;
  localparam logic [7:0]  FILL_X1  = 8'(SCREEN_WIDTH - 1);
  localparam logic [7:0]  FILL_Y1  = 8'(SCREEN_HEIGHT - 1);
  localparam logic [15:0] FILL_CNT = 16'(SCREEN_WIDTH * SCREEN_HEIGHT - 1);

  logic [4:0]  glyph_w_q;
  logic [5:0]  glyph_h_q;
  logic [7:0]  x0_q, y0_q, x1_q, y1_q;
  logic [15:0] fore_q, back_q;
  logic [6:0]  char_q;
  logic [7:0]  madctl_q;
  logic [15:0] count_q;
  logic [4:0]  row_q;
  logic [3:0]  col_q;
  logic        out_valid_q;
  logic        is_data_q, frame_end_q, op_end_q;
  logic [7:0]  byte_q;

  logic [15:0] font_mem [FONT_ROWS];
  logic [15:0] font_q;
  logic        font_ok_q;

  logic [4:0]    ew;
  logic [5:0]    eh;
  logic [8:0]    char_x1, char_y1;
  logic [6:0]    code_off;
  logic [12:0]   prod;
  logic [FW-1:0] raddr, waddr;
  logic          rd_ok, wr_ok;
  logic [15:0]   line, colour;
  logic [4:0]    bit_sel;
  logic          solid, col_end, row_end;
  logic          byte_dc, byte_fe, byte_oe;
  logic [7:0]    byte_v;

  always_comb begin
    if (glyph_w_q == 5'd0) ew = 5'd1;
    else if (glyph_w_q > 5'd16) ew = 5'd16;
    else ew = glyph_w_q;
    if (glyph_h_q == 6'd0) eh = 6'd1;
    else if (glyph_h_q > 6'd32) eh = 6'd32;
    else eh = glyph_h_q;
  end

  assign char_x1 = 9'(pos_x_i) + 9'(ew) - 9'd1;
  assign char_y1 = 9'(pos_y_i) + 9'(eh) - 9'd1;

  assign stat_o.pix_ok = (9'(pos_x_i) < 9'(SCREEN_WIDTH)) && (9'(pos_y_i) < 9'(SCREEN_HEIGHT));
  assign stat_o.char_ok = (char_code_i >= lcdseq_pkg::CHAR_FIRST)
                       && (char_code_i <= lcdseq_pkg::CHAR_LAST);

  assign solid   = (char_q == 7'd0);
  assign col_end = (5'(col_q) + 5'd1) >= ew;
  assign row_end = (6'(row_q) + 6'd1) >= eh;
  assign stat_o.pix_last = solid ? (count_q == 16'd0) : (col_end && row_end);
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  assign code_off = char_q - lcdseq_pkg::CHAR_FIRST[6:0];
  assign prod     = 13'(code_off) * 13'(eh);
  assign raddr    = FW'(prod) + FW'(row_q);
  assign rd_ok    = raddr < FW'(FONT_ROWS);
  assign waddr    = FW'(font_addr_i);
  assign wr_ok    = waddr < FW'(FONT_ROWS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.font_load && wr_ok) begin
      font_mem[waddr[AW-1:0]] <= font_row_i;
    end
    font_q    <= font_mem[raddr[AW-1:0]];
    font_ok_q <= rd_ok;
  end

  always_comb begin
    line    = font_ok_q ? font_q : 16'd0;
    bit_sel = ew - 5'd1 - 5'(col_q);
    if (solid) colour = fore_q;
    else if (5'(col_q) >= ew) colour = back_q;
    else colour = line[bit_sel[3:0]] ? fore_q : back_q;
  end

  always_comb begin
    byte_dc = 1'b1;
    byte_fe = 1'b0;
    byte_oe = 1'b0;
    byte_v  = 8'd0;
    unique case (cmd_i.src)
      lcdseq_pkg::SRC_WIN: begin
        unique case (cmd_i.win_idx)
          lcdseq_pkg::WB_CASET: begin
            byte_dc = 1'b0;
            byte_v  = lcdseq_pkg::CMD_CASET;
            byte_fe = 1'b1;
          end
          lcdseq_pkg::WB_XS: byte_v = x0_q;
          lcdseq_pkg::WB_XE: begin
            byte_v  = x1_q;
            byte_fe = 1'b1;
          end
          lcdseq_pkg::WB_RASET: begin
            byte_dc = 1'b0;
            byte_v  = lcdseq_pkg::CMD_RASET;
            byte_fe = 1'b1;
          end
          lcdseq_pkg::WB_YS: byte_v = y0_q;
          lcdseq_pkg::WB_YE: begin
            byte_v  = y1_q;
            byte_fe = 1'b1;
          end
          lcdseq_pkg::WB_RAMWR: begin
            byte_dc = 1'b0;
            byte_v  = lcdseq_pkg::CMD_RAMWR;
            byte_fe = 1'b1;
          end
          default: byte_v = 8'd0;
        endcase
      end
      lcdseq_pkg::SRC_PIX_HI: byte_v = colour[15:8];
      lcdseq_pkg::SRC_PIX_LO: begin
        byte_v  = colour[7:0];
        byte_fe = stat_o.pix_last;
        byte_oe = stat_o.pix_last;
      end
      lcdseq_pkg::SRC_ROT_CMD: begin
        byte_dc = 1'b0;
        byte_v  = lcdseq_pkg::CMD_MADCTL;
        byte_fe = 1'b1;
      end
      lcdseq_pkg::SRC_ROT_DATA: begin
        byte_v  = madctl_q;
        byte_fe = 1'b1;
        byte_oe = 1'b1;
      end
      default: byte_v = 8'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glyph_w_q <= 5'd8;
      glyph_h_q <= 6'd16;
      x0_q      <= '0;
      y0_q      <= '0;
      x1_q      <= '0;
      y1_q      <= '0;
      fore_q    <= '0;
      back_q    <= '0;
      char_q    <= '0;
      madctl_q  <= '0;
      count_q   <= '0;
      row_q     <= '0;
      col_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == lcdseq_pkg::REG_GLYPH_W) glyph_w_q <= cfg_wdata_i[4:0];
        if (cfg_idx_i == lcdseq_pkg::REG_GLYPH_H) glyph_h_q <= cfg_wdata_i;
      end
      if (cmd_i.start_pixel) begin
        x0_q    <= pos_x_i;
        x1_q    <= pos_x_i;
        y0_q    <= pos_y_i;
        y1_q    <= pos_y_i;
        fore_q  <= fore_color_i;
        char_q  <= '0;
        count_q <= '0;
        row_q   <= '0;
        col_q   <= '0;
      end
      if (cmd_i.start_fill) begin
        x0_q    <= '0;
        y0_q    <= '0;
        x1_q    <= FILL_X1;
        y1_q    <= FILL_Y1;
        fore_q  <= fore_color_i;
        char_q  <= '0;
        count_q <= FILL_CNT;
        row_q   <= '0;
        col_q   <= '0;
      end
      if (cmd_i.start_char) begin
        x0_q    <= pos_x_i;
        y0_q    <= pos_y_i;
        x1_q    <= char_x1[7:0];
        y1_q    <= char_y1[7:0];
        fore_q  <= fore_color_i;
        back_q  <= back_color_i;
        char_q  <= char_code_i[6:0];
        count_q <= '0;
        row_q   <= '0;
        col_q   <= '0;
      end
      if (cmd_i.start_rot) begin
        madctl_q <= lcdseq_pkg::madctl_of(rotation_i);
      end
      if (cmd_i.pix_step) begin
        if (stat_o.pix_last) begin
          row_q <= '0;
          col_q <= '0;
        end else if (solid) begin
          count_q <= count_q - 16'd1;
        end else if (col_end) begin
          col_q <= '0;
          row_q <= row_q + 5'd1;
        end else begin
          col_q <= col_q + 4'd1;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      is_data_q   <= byte_dc;
      byte_q      <= byte_v;
      frame_end_q <= byte_fe;
      op_end_q    <= byte_oe;
    end
  end

  assign out_valid_o = out_valid_q;
  assign is_data_o   = is_data_q;
  assign out_byte_o  = byte_q;
  assign frame_end_o = frame_end_q;
  assign op_end_o    = op_end_q;

  `include "lcd_draw_command_sequencer_top_macros.svh"

  `LCDSEQ_ASSERT_IMPL(a_emit_into_free, cmd_i.emit, !out_valid_q || !out_stall_i, "result overwrites a pending transaction")
  `LCDSEQ_ASSERT_IMPL(a_op_end_frame, out_valid_q && op_end_q, frame_end_q, "operation end without frame end")

endmodule

[design/lcd_draw_command_sequencer_top.sv]
// Byte sequencer for a small SPI colour LCD, driven by pulls.
// Input channel (in_valid_i / in_stall_o) carries one action per transaction:
// draw pixel, fill screen, draw character, set rotation, next byte or load a
// font row. Start actions take effect only while idle and produce no output;
// font loads are stored whenever accepted. Each next-byte transaction while an
// operation is active produces one output transaction (out_valid_o /
// out_stall_i) with the byte, its data/command level, frame end and
// operation end. Configuration is a plain write port (cfg_we_i, cfg_idx_i,
// cfg_wdata_i) for glyph width and height.
// A window or rotation byte appears in the cycle after its next-byte
// transaction; a pixel byte passes the read state, with a registered font
// memory read, and the colour step, during which the input stalls. Other
// bytes sustain one per cycle while the receiver does not stall.
// Reset returns the sequencer to idle with glyph width 8 and height 16; font
// memory contents are not cleared and must be loaded before use.
// While the receiver stalls, the pending output holds and the input channel
// stalls until that transaction is taken.
module lcd_draw_command_sequencer_top #(
  parameter int unsigned SCREEN_WIDTH  = 160,
  parameter int unsigned SCREEN_HEIGHT = 128,
  parameter int unsigned FONT_ROWS     = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [5:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  action_i,
  input  logic [7:0]  pos_x_i,
  input  logic [7:0]  pos_y_i,
  input  logic [15:0] fore_color_i,
  input  logic [15:0] back_color_i,
  input  logic [7:0]  char_code_i,
  input  logic [1:0]  rotation_i,
  input  logic [11:0] font_addr_i,
  input  logic [15:0] font_row_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        is_data_o,
  output logic [7:0]  out_byte_o,
  output logic        frame_end_o,
  output logic        op_end_o
);

  lcdseq_pkg::ctrl_cmd_t cmd;
  lcdseq_pkg::dp_stat_t  stat;

  lcdseq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .stat_i     (stat),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  lcdseq_dp #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .FONT_ROWS     (FONT_ROWS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .fore_color_i (fore_color_i),
    .back_color_i (back_color_i),
    .char_code_i  (char_code_i),
    .rotation_i   (rotation_i),
    .font_addr_i  (font_addr_i),
    .font_row_i   (font_row_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .is_data_o    (is_data_o),
    .out_byte_o   (out_byte_o),
    .frame_end_o  (frame_end_o),
    .op_end_o     (op_end_o)
  );

endmodule

[test/testbench.sv]
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SCR_W = 160;
  localparam int unsigned SCR_H = 128;
  localparam int unsigned FONT_DEPTH = 4096;
  localparam int unsigned CYCLE_LIMIT = 4000000;

  localparam logic [4:0] SEQ_IDLE     = 5'd0;
  localparam logic [4:0] SEQ_WIN_LAST = 5'd11;
  localparam logic [4:0] SEQ_PIX      = 5'd12;
  localparam logic [4:0] SEQ_ROT_CMD  = 5'd13;
  localparam logic [4:0] SEQ_ROT_DATA = 5'd14;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [15:0] fore_color;
    logic [15:0] back_color;
    logic [7:0]  char_code;
    logic [1:0]  rotation;
    logic [11:0] font_addr;
    logic [15:0] font_row;
  } draw_req_t;

  localparam int unsigned REQ_W = $bits(draw_req_t);

  typedef struct packed {
    logic       is_data;
    logic [7:0] out_byte;
    logic       frame_end;
    logic       op_end;
  } lcd_byte_t;

  typedef struct {
    logic [4:0]  step;
    logic [7:0]  x0, y0, x1, y1;
    logic [15:0] fore, back;
    logic [6:0]  chr;
    logic [7:0]  madctl;
    logic [15:0] run_left;
    logic [4:0]  row;
    logic [3:0]  col;
    logic        low_half;
    logic [4:0]  gw;
    logic [5:0]  gh;
  } seq_state_t;

  // Index 0 tracks the stimulus as it is generated, index 1 the accepted transactions.
  seq_state_t  seq_st[2];
  logic [15:0] font_mem[2][FONT_DEPTH];
  bit          font_loaded[FONT_DEPTH];

  draw_req_t   pending_reqs[$];
  lcd_byte_t   expected_bytes[$];
  bit          failed;
  int unsigned cycle_count;
  int unsigned bytes_seen;
  int unsigned in_gap, out_gap, long_hold;
  bit          long_hold_done;

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [5:0]  cfg_wdata_i;
  logic        in_valid_i, in_stall_o;
  draw_req_t   drv;
  logic        out_valid_o, out_stall_i;
  logic        is_data_o, frame_end_o, op_end_o;
  logic [7:0]  out_byte_o;

  lcd_draw_command_sequencer_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (drv.action),
    .pos_x_i      (drv.pos_x),
    .pos_y_i      (drv.pos_y),
    .fore_color_i (drv.fore_color),
    .back_color_i (drv.back_color),
    .char_code_i  (drv.char_code),
    .rotation_i   (drv.rotation),
    .font_addr_i  (drv.font_addr),
    .font_row_i   (drv.font_row),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .is_data_o    (is_data_o),
    .out_byte_o   (out_byte_o),
    .frame_end_o  (frame_end_o),
    .op_end_o     (op_end_o)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned glyph_w(input int m);
    if (seq_st[m].gw == 0) return 1;
    if (seq_st[m].gw > 16) return 16;
    return seq_st[m].gw;
  endfunction

  function automatic int unsigned glyph_h(input int m);
    if (seq_st[m].gh == 0) return 1;
    if (seq_st[m].gh > 32) return 32;
    return seq_st[m].gh;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void start_window(input int m);
    seq_st[m].step = 5'd1;
    seq_st[m].row = '0;
    seq_st[m].col = '0;
    seq_st[m].low_half = 1'b0;
  endfunction

  // Advances sequencer state m by one transaction; returns 1 when a byte results.
  function automatic bit sequencer_step(input int m, input draw_req_t r, output lcd_byte_t b);
    int unsigned w, h, addr;
    logic [15:0] line, c;
    bit          last;
    w = glyph_w(m);
    h = glyph_h(m);
    b = '0;
    if (r.action == lcdseq_pkg::ACT_LOAD) begin
      font_mem[m][r.font_addr] = r.font_row;
      return 0;
    end
    if (r.action == lcdseq_pkg::ACT_PIXEL || r.action == lcdseq_pkg::ACT_FILL ||
        r.action == lcdseq_pkg::ACT_CHAR || r.action == lcdseq_pkg::ACT_ROT) begin
      if (seq_st[m].step != SEQ_IDLE) return 0;
      if (r.action == lcdseq_pkg::ACT_PIXEL) begin
        if (r.pos_x >= SCR_W || r.pos_y >= SCR_H) return 0;
        seq_st[m].x0 = r.pos_x; seq_st[m].x1 = r.pos_x;
        seq_st[m].y0 = r.pos_y; seq_st[m].y1 = r.pos_y;
        seq_st[m].fore = r.fore_color;
        seq_st[m].chr = '0;
        seq_st[m].run_left = '0;
        start_window(m);
      end else if (r.action == lcdseq_pkg::ACT_FILL) begin
        seq_st[m].x0 = '0; seq_st[m].y0 = '0;
        seq_st[m].x1 = 8'(SCR_W - 1); seq_st[m].y1 = 8'(SCR_H - 1);
        seq_st[m].fore = r.fore_color;
        seq_st[m].chr = '0;
        seq_st[m].run_left = 16'(SCR_W * SCR_H - 1);
        start_window(m);
      end else if (r.action == lcdseq_pkg::ACT_CHAR) begin
        if (r.char_code < lcdseq_pkg::CHAR_FIRST || r.char_code > lcdseq_pkg::CHAR_LAST)
          return 0;
        seq_st[m].x0 = r.pos_x; seq_st[m].y0 = r.pos_y;
        seq_st[m].x1 = 8'(r.pos_x + w - 1);
        seq_st[m].y1 = 8'(r.pos_y + h - 1);
        seq_st[m].fore = r.fore_color;
        seq_st[m].back = r.back_color;
        seq_st[m].chr = r.char_code[6:0];
        seq_st[m].run_left = '0;
        start_window(m);
      end else begin
        seq_st[m].madctl = lcdseq_pkg::madctl_of(r.rotation);
        seq_st[m].step = SEQ_ROT_CMD;
      end
      return 0;
    end
    if (r.action != lcdseq_pkg::ACT_NEXT) return 0;
    if (seq_st[m].step >= 5'd1 && seq_st[m].step <= SEQ_WIN_LAST) begin
      case (seq_st[m].step)
        5'd1:    b = '{1'b0, lcdseq_pkg::CMD_CASET, 1'b1, 1'b0};
        5'd3:    b = '{1'b1, seq_st[m].x0, 1'b0, 1'b0};
        5'd5:    b = '{1'b1, seq_st[m].x1, 1'b1, 1'b0};
        5'd6:    b = '{1'b0, lcdseq_pkg::CMD_RASET, 1'b1, 1'b0};
        5'd8:    b = '{1'b1, seq_st[m].y0, 1'b0, 1'b0};
        5'd10:   b = '{1'b1, seq_st[m].y1, 1'b1, 1'b0};
        5'd11:   b = '{1'b0, lcdseq_pkg::CMD_RAMWR, 1'b1, 1'b0};
        default: b = '{1'b1, 8'h00, 1'b0, 1'b0};
      endcase
      seq_st[m].step = seq_st[m].step + 5'd1;
      return 1;
    end
    if (seq_st[m].step == SEQ_PIX) begin
      if (seq_st[m].chr == 0) begin
        c = seq_st[m].fore;
      end else begin
        addr = (seq_st[m].chr - 32) * h + seq_st[m].row;
        line = (addr < FONT_DEPTH) ? font_mem[m][addr] : 16'h0;
        if (seq_st[m].col >= w) c = seq_st[m].back;
        else c = line[w - 1 - seq_st[m].col] ? seq_st[m].fore : seq_st[m].back;
      end
      if (!seq_st[m].low_half) begin
        b = '{1'b1, c[15:8], 1'b0, 1'b0};
        seq_st[m].low_half = 1'b1;
        return 1;
      end
      seq_st[m].low_half = 1'b0;
      last = 1'b0;
      if (seq_st[m].chr == 0) begin
        if (seq_st[m].run_left == 0) last = 1'b1;
        else seq_st[m].run_left = seq_st[m].run_left - 16'd1;
      end else if (seq_st[m].col + 1 >= w) begin
        seq_st[m].col = '0;
        if (seq_st[m].row + 1 >= h) last = 1'b1;
        else seq_st[m].row = seq_st[m].row + 5'd1;
      end else begin
        seq_st[m].col = seq_st[m].col + 4'd1;
      end
      b = '{1'b1, c[7:0], last, last};
      if (last) begin
        seq_st[m].step = SEQ_IDLE;
        seq_st[m].row = '0;
        seq_st[m].col = '0;
      end
      return 1;
    end
    if (seq_st[m].step == SEQ_ROT_CMD) begin
      b = '{1'b0, lcdseq_pkg::CMD_MADCTL, 1'b1, 1'b0};
      seq_st[m].step = SEQ_ROT_DATA;
      return 1;
    end
    if (seq_st[m].step == SEQ_ROT_DATA) begin
      b = '{1'b1, seq_st[m].madctl, 1'b1, 1'b1};
      seq_st[m].step = SEQ_IDLE;
      return 1;
    end
    seq_st[m].step = SEQ_IDLE;
    return 0;
  endfunction

  // Input driver and predictor for accepted transactions.
  always @(posedge clk_i) begin
    lcd_byte_t b;
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      if (in_valid_i && !in_stall_o) begin
        if (sequencer_step(1, drv, b)) expected_bytes.push_back(b);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_valid_i <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (pending_reqs.size() > 0) begin
          in_valid_i <= 1'b1;
          drv <= pending_reqs.pop_front();
          in_gap <= idle_len();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor and receiver stall.
  always @(posedge clk_i) begin
    lcd_byte_t got, want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{is_data_o, out_byte_o, frame_end_o, op_end_o};
        bytes_seen <= bytes_seen + 1;
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected transaction %h", $time, got);
          failed <= 1'b1;
        end else begin
          want = expected_bytes.pop_front();
          if (got.is_data !== want.is_data) begin
            $display("%0t: is_data expected %b actual %b", $time, want.is_data, got.is_data);
            failed <= 1'b1;
          end
          if (got.out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %h actual %h", $time, want.out_byte,
                     got.out_byte);
            failed <= 1'b1;
          end
          if (got.frame_end !== want.frame_end) begin
            $display("%0t: frame_end expected %b actual %b", $time, want.frame_end,
                     got.frame_end);
            failed <= 1'b1;
          end
          if (got.op_end !== want.op_end) begin
            $display("%0t: op_end expected %b actual %b", $time, want.op_end, got.op_end);
            failed <= 1'b1;
          end
        end
      end
      if (!long_hold_done && bytes_seen >= 100) begin
        long_hold_done <= 1'b1;
        long_hold <= 400;
        out_stall_i <= 1'b1;
      end else if (long_hold > 0) begin
        long_hold <= long_hold - 1;
        out_stall_i <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_gap <= idle_len();
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic draw_req_t random_req(input logic [2:0] act);
    draw_req_t r;
    r = REQ_W'({$urandom, $urandom, $urandom});
    r.action = act;
    return r;
  endfunction

  // Queues one transaction, tracking the generation-side state.
  function automatic void queue_req(input draw_req_t r);
    lcd_byte_t b;
    void'(sequencer_step(0, r, b));
    if (r.action == lcdseq_pkg::ACT_LOAD) font_loaded[r.font_addr] = 1'b1;
    pending_reqs.push_back(r);
  endfunction

  function automatic void load_glyph(input logic [7:0] code);
    int unsigned base, h;
    draw_req_t   r;
    h = glyph_h(0);
    base = (code - 32) * h;
    for (int unsigned i = 0; i < h; i++) begin
      if (!font_loaded[base + i]) begin
        r = random_req(lcdseq_pkg::ACT_LOAD);
        r.font_addr = 12'(base + i);
        queue_req(r);
      end
    end
  endfunction

  function automatic bit printable(input draw_req_t r);
    return r.action == lcdseq_pkg::ACT_CHAR && r.char_code >= lcdseq_pkg::CHAR_FIRST &&
           r.char_code <= lcdseq_pkg::CHAR_LAST;
  endfunction

  // Queues a start and enough next-byte pulls to finish it; returns the item count.
  function automatic int unsigned run_op(input draw_req_t r, input bit noisy);
    int unsigned n;
    draw_req_t   x;
    if (printable(r)) load_glyph(r.char_code);
    queue_req(r);
    n = 1;
    while (seq_st[0].step != SEQ_IDLE) begin
      if (noisy && $urandom_range(0, 9) == 0) begin
        x = random_req(3'($urandom_range(0, 7)));
        if (printable(x)) load_glyph(x.char_code);
        queue_req(x);
      end else begin
        queue_req(random_req(lcdseq_pkg::ACT_NEXT));
        n++;
      end
    end
    return n;
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid_i || expected_bytes.size() > 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_glyph(input logic [5:0] w, input logic [5:0] h);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= lcdseq_pkg::REG_GLYPH_W;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_idx_i <= lcdseq_pkg::REG_GLYPH_H;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    for (int m = 0; m < 2; m++) begin
      seq_st[m].gw = w[4:0];
      seq_st[m].gh = h;
    end
  endtask

  task automatic random_phase(input int unsigned quota);
    int unsigned n, k;
    draw_req_t   r;
    n = 0;
    while (n < quota) begin
      k = $urandom_range(0, 99);
      if (k < 40) begin
        r = random_req(lcdseq_pkg::ACT_PIXEL);
        if ($urandom_range(0, 9) != 0) begin
          r.pos_x = 8'($urandom_range(0, SCR_W - 1));
          r.pos_y = 8'($urandom_range(0, SCR_H - 1));
        end
      end else if (k < 75) begin
        r = random_req(lcdseq_pkg::ACT_CHAR);
        if ($urandom_range(0, 9) != 0) r.char_code = 8'($urandom_range(32, 126));
      end else if (k < 90) begin
        r = random_req(lcdseq_pkg::ACT_ROT);
      end else begin
        r = random_req(3'($urandom_range(4, 7)));
      end
      n += run_op(r, 1'b1);
    end
  endtask

  initial begin
    draw_req_t r;
    failed = 1'b0;
    cycle_count = 0;
    bytes_seen = 0;
    in_gap = 0;
    out_gap = 0;
    long_hold = 0;
    long_hold_done = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = lcdseq_pkg::REG_GLYPH_W;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    drv = '0;
    for (int m = 0; m < 2; m++) begin
      seq_st[m] = '{default: '0};
      seq_st[m].gw = 5'd8;
      seq_st[m].gh = 6'd16;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < 4; i++) begin
      r = random_req(lcdseq_pkg::ACT_ROT);
      r.rotation = 2'(i);
      void'(run_op(r, 1'b0));
    end
    r = random_req(lcdseq_pkg::ACT_PIXEL); r.pos_x = 8'd0; r.pos_y = 8'd0;
    r.fore_color = 16'h0000;
    void'(run_op(r, 1'b0));
    r = random_req(lcdseq_pkg::ACT_PIXEL); r.pos_x = 8'(SCR_W - 1); r.pos_y = 8'(SCR_H - 1);
    r.fore_color = 16'hFFFF;
    void'(run_op(r, 1'b0));
    r = random_req(lcdseq_pkg::ACT_PIXEL); r.pos_x = 8'(SCR_W); r.pos_y = 8'd0;
    void'(run_op(r, 1'b0));
    r = random_req(lcdseq_pkg::ACT_PIXEL); r.pos_x = 8'd0; r.pos_y = 8'(SCR_H);
    void'(run_op(r, 1'b0));
    r = random_req(lcdseq_pkg::ACT_PIXEL); r.pos_x = 8'hFF; r.pos_y = 8'hFF;
    void'(run_op(r, 1'b0));
    r = random_req(lcdseq_pkg::ACT_CHAR); r.char_code = 8'd0; void'(run_op(r, 1'b0));
    r = random_req(lcdseq_pkg::ACT_CHAR); r.char_code = 8'd31; void'(run_op(r, 1'b0));
    r = random_req(lcdseq_pkg::ACT_CHAR); r.char_code = 8'd127; void'(run_op(r, 1'b0));
    r = random_req(lcdseq_pkg::ACT_CHAR); r.char_code = 8'd255; void'(run_op(r, 1'b0));
    r = random_req(lcdseq_pkg::ACT_LOAD); r.font_addr = 12'hFFF; r.font_row = 16'hFFFF;
    queue_req(r);
    r = random_req(lcdseq_pkg::ACT_CHAR); r.char_code = lcdseq_pkg::CHAR_FIRST;
    r.pos_x = 8'hFF; r.pos_y = 8'hFF;
    r.fore_color = 16'hFFFF; r.back_color = 16'h0000;
    void'(run_op(r, 1'b0));
    r = random_req(lcdseq_pkg::ACT_CHAR); r.char_code = lcdseq_pkg::CHAR_LAST;
    r.pos_x = 8'd250; r.pos_y = 8'd0;
    r.fore_color = 16'h0000; r.back_color = 16'hFFFF;
    void'(run_op(r, 1'b1));
    queue_req(random_req(lcdseq_pkg::ACT_NEXT));
    queue_req(random_req(3'd6));
    queue_req(random_req(3'd7));
    r = random_req(lcdseq_pkg::ACT_FILL); r.fore_color = 16'hA55A;
    void'(run_op(r, 1'b1));
    wait_drained();

    random_phase(130);
    wait_drained();
    write_glyph(6'd0, 6'd0);
    random_phase(120);
    wait_drained();
    write_glyph(6'd16, 6'd32);
    random_phase(120);
    wait_drained();
    write_glyph(6'd31, 6'd63);
    random_phase(60);
    wait_drained();
    write_glyph(6'($urandom_range(1, 16)), 6'($urandom_range(1, 32)));
    random_phase(120);
    wait_drained();

    if (!failed && expected_bytes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
